>>> design/rti_pkg.sv
// Shared types and constants of the ray / triangle intersection block.
// Used by rti_setup, rti_div_pipe and ray_triangle_intersect.
`timescale 1ns / 1ps

package rti_pkg;

  localparam int COORD_BITS = 16;
  localparam int DIST_BITS  = 32;
  localparam int VERT_W     = 3 * COORD_BITS;
  localparam int EPS_W      = 16;
  localparam int NRM_W      = 16;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 64;

  localparam int EDGE_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * EDGE_W;
  localparam int DIFF_W = PROD_W + 1;
  localparam int TRIP_W = EDGE_W + DIFF_W;
  localparam int DET_W  = TRIP_W + 2;
  localparam int MAG_W  = DET_W - 1;

  localparam int FRAC_BITS = 16;
  localparam int QUOT_BITS = 47;
  localparam int INT_BITS  = QUOT_BITS - FRAC_BITS;
  localparam int RES_W     = QUOT_BITS + 2;
  localparam int DIV_LAT   = QUOT_BITS + 2;

  localparam logic CMD_CLOSEST = 1'b0;
  localparam logic CMD_OCCLUDE = 1'b1;

  localparam logic [1:0] REG_VERTEX_A = 2'd0;
  localparam logic [1:0] REG_VERTEX_B = 2'd1;
  localparam logic [1:0] REG_VERTEX_C = 2'd2;
  localparam logic [1:0] REG_EPSILON  = 2'd3;

  typedef struct packed {
    logic                         command;
    logic signed [COORD_BITS-1:0] ray_origin_x;
    logic signed [COORD_BITS-1:0] ray_origin_y;
    logic signed [COORD_BITS-1:0] ray_origin_z;
    logic signed [COORD_BITS-1:0] ray_dir_x;
    logic signed [COORD_BITS-1:0] ray_dir_y;
    logic signed [COORD_BITS-1:0] ray_dir_z;
    logic [DIST_BITS-2:0]         max_t;
  } ray_t;

  typedef struct packed {
    logic                         hit;
    logic signed [DIST_BITS-1:0]  distance;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
    logic signed [NRM_W-1:0]      normal_x;
    logic signed [NRM_W-1:0]      normal_y;
    logic signed [NRM_W-1:0]      normal_z;
  } result_t;

  typedef struct packed {
    logic [2:0][EDGE_W-1:0] ab;
    logic [2:0][EDGE_W-1:0] ac;
    logic [DIFF_W-1:0]      left_det;
    logic [2:0][NRM_W-1:0]  normal;
  } geom_t;

endpackage

>>> design/rti_setup.sv
// Triangle setup: edges, left determinant and unit normal from the vertices.
// Edge terms are a short pipeline; the normal is built by a multi-cycle sequencer.
// Depends on rti_pkg.
`timescale 1ns / 1ps

module rti_setup (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [rti_pkg::VERT_W-1:0]  vertex_a,
  input  logic [rti_pkg::VERT_W-1:0]  vertex_b,
  input  logic [rti_pkg::VERT_W-1:0]  vertex_c,
  input  logic                        start,
  output rti_pkg::geom_t              geom,
  output logic                        busy
);

  localparam int CB     = rti_pkg::COORD_BITS;
  localparam int EW     = rti_pkg::EDGE_W;
  localparam int PW     = rti_pkg::PROD_W;
  localparam int DW     = rti_pkg::DIFF_W;
  localparam int NW     = rti_pkg::NRM_W;
  localparam int MN_W   = 30;
  localparam int SQ_W   = 2 * MN_W;
  localparam int N2_W   = SQ_W + 2;
  localparam int NF     = 14;
  localparam int NORM_W = MN_W + 1;
  localparam int DV_W   = MN_W + NF + 1;
  localparam int RM_W   = NORM_W + 1;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_WAIT  = 4'd1;
  localparam logic [3:0] ST_LOAD  = 4'd2;
  localparam logic [3:0] ST_SHIFT = 4'd3;
  localparam logic [3:0] ST_SQ    = 4'd4;
  localparam logic [3:0] ST_ACC   = 4'd5;
  localparam logic [3:0] ST_ROOT  = 4'd6;
  localparam logic [3:0] ST_DPREP = 4'd7;
  localparam logic [3:0] ST_DIV   = 4'd8;

  localparam logic [5:0] WAIT_LAST = 6'd3;
  localparam logic [5:0] DIV_LAST  = 6'(DV_W - 1);
  localparam logic [1:0] IDX_LAST  = 2'd2;

  logic signed [CB-1:0] va [3], vb [3], vc [3];
  logic signed [EW-1:0] ab [3], ac [3], u [3], w [3];
  logic signed [PW-1:0] lp1, lp2;
  logic signed [PW-1:0] cpa [3], cpb [3];
  logic signed [DW-1:0] left_det;
  logic signed [DW-1:0] cr [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i] = $signed(vertex_a[i*CB +: CB]);
      vb[i] = $signed(vertex_b[i*CB +: CB]);
      vc[i] = $signed(vertex_c[i*CB +: CB]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ab[i] <= EW'(va[i]) - EW'(vb[i]);
      ac[i] <= EW'(va[i]) - EW'(vc[i]);
      u[i]  <= EW'(vb[i]) - EW'(va[i]);
      w[i]  <= EW'(vc[i]) - EW'(vb[i]);
    end
    lp1    <= ab[1] * ac[2];
    lp2    <= ab[2] * ac[1];
    cpa[0] <= u[1] * w[2];
    cpb[0] <= u[2] * w[1];
    cpa[1] <= u[2] * w[0];
    cpb[1] <= u[0] * w[2];
    cpa[2] <= u[0] * w[1];
    cpb[2] <= u[1] * w[0];
    left_det <= DW'(lp1) - DW'(lp2);
    for (int i = 0; i < 3; i++) begin
      cr[i] <= DW'(cpa[i]) - DW'(cpb[i]);
    end
  end

  // normal sequencer
  logic [3:0]        state;
  logic [5:0]        cnt;
  logic [1:0]        idx;
  logic [DW-1:0]     mag [3];
  logic              sgn [3];
  logic [SQ_W-1:0]   sq;
  logic [N2_W-1:0]   n2;
  logic [N2_W-1:0]   rv, rr, rb;
  logic [DV_W-1:0]   dv;
  logic [RM_W-1:0]   rem;
  logic [NW-1:0]     nrm [3];

  logic              big;
  logic [N2_W-1:0]   n2_next;
  logic [N2_W:0]     root_sum;
  logic              root_ge;
  logic [N2_W-1:0]   rr_next;
  logic [NORM_W-1:0] norm;
  logic [RM_W-1:0]   trial;
  logic              div_ge;
  logic [DV_W-1:0]   dv_next;

  always_comb begin
    big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      big = big | (|mag[i][DW-1:MN_W]);
    end
    n2_next  = n2 + N2_W'(sq);
    root_sum = {1'b0, rr} + {1'b0, rb};
    root_ge  = {1'b0, rv} >= root_sum;
    rr_next  = root_ge ? (rr >> 1) + rb : rr >> 1;
    norm     = rr[NORM_W-1:0];
    trial    = {rem[RM_W-2:0], dv[DV_W-1]};
    div_ge   = trial >= RM_W'(norm);
    dv_next  = {dv[DV_W-2:0], div_ge};
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      state <= ST_WAIT;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
        end
        ST_WAIT: begin
          cnt <= cnt + 6'd1;
          if (cnt == WAIT_LAST) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            sgn[i] <= cr[i] < 0;
            mag[i] <= cr[i] < 0 ? DW'(-cr[i]) : DW'(cr[i]);
          end
          state <= ST_SHIFT;
        end
        ST_SHIFT: begin
          if (big) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] >> 1;
            end
          end else begin
            idx   <= '0;
            n2    <= '0;
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          sq    <= mag[idx][MN_W-1:0] * mag[idx][MN_W-1:0];
          state <= ST_ACC;
        end
        ST_ACC: begin
          n2 <= n2_next;
          if (idx == IDX_LAST) begin
            rv    <= n2_next;
            rr    <= '0;
            rb    <= N2_W'(1) << (N2_W - 2);
            state <= ST_ROOT;
          end else begin
            idx   <= idx + 2'd1;
            state <= ST_SQ;
          end
        end
        ST_ROOT: begin
          if (root_ge) begin
            rv <= rv - root_sum[N2_W-1:0];
          end
          rr <= rr_next;
          rb <= rb >> 2;
          if (rb == N2_W'(1)) begin
            if (rr_next == '0) begin
              for (int i = 0; i < 3; i++) begin
                nrm[i] <= '0;
              end
              state <= ST_IDLE;
            end else begin
              idx   <= '0;
              state <= ST_DPREP;
            end
          end
        end
        ST_DPREP: begin
          dv    <= DV_W'({mag[idx][MN_W-1:0], NF'(0)}) + DV_W'(norm >> 1);
          rem   <= '0;
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem <= div_ge ? trial - RM_W'(norm) : trial;
          dv  <= dv_next;
          cnt <= cnt + 6'd1;
          if (cnt == DIV_LAST) begin
            nrm[idx] <= sgn[idx] ? -dv_next[NW-1:0] : dv_next[NW-1:0];
            if (idx == IDX_LAST) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + 2'd1;
              state <= ST_DPREP;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy = state != ST_IDLE;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      geom.ab[i]     = ab[i];
      geom.ac[i]     = ac[i];
      geom.normal[i] = nrm[i];
    end
    geom.left_det = left_det;
  end

endmodule

>>> design/rti_div_pipe.sv
// Pipelined restoring divider: floor(num * 2^16 / den) with sign and clamp.
// One quotient bit per stage. Depends on rti_pkg.
`timescale 1ns / 1ps

module rti_div_pipe (
  input  logic                              clk,
  input  logic                              en,
  input  logic [rti_pkg::MAG_W-1:0]         num,
  input  logic                              neg,
  input  logic [rti_pkg::MAG_W-1:0]         den,
  output logic signed [rti_pkg::RES_W-1:0]  quot
);

  localparam int MW = rti_pkg::MAG_W;
  localparam int QB = rti_pkg::QUOT_BITS;
  localparam int IB = rti_pkg::INT_BITS;
  localparam int FB = rti_pkg::FRAC_BITS;
  localparam int RW = rti_pkg::RES_W;

  localparam logic signed [RW-1:0] QLIM = {2'b01, {QB{1'b0}}};

  logic [MW-1:0] rem [QB+1];
  logic [QB-1:0] sr  [QB+1];
  logic [MW-1:0] dd  [QB+1];
  logic          ng  [QB+1];
  logic          ov  [QB+1];

  logic [MW:0]   trial [QB];
  logic          ge    [QB];

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      trial[k] = {rem[k], sr[k][QB-1]};
      ge[k]    = trial[k] >= {1'b0, dd[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num >> IB;
      sr[0]  <= {num[IB-1:0], FB'(0)};
      dd[0]  <= den;
      ng[0]  <= neg;
      ov[0]  <= (num >> IB) >= den;
      for (int k = 0; k < QB; k++) begin
        rem[k+1] <= ge[k] ? MW'(trial[k] - {1'b0, dd[k]}) : trial[k][MW-1:0];
        sr[k+1]  <= {sr[k][QB-2:0], ge[k]};
        dd[k+1]  <= dd[k];
        ng[k+1]  <= ng[k];
        ov[k+1]  <= ov[k];
      end
      if (ov[QB]) begin
        quot <= ng[QB] ? -QLIM : QLIM;
      end else if (ng[QB]) begin
        quot <= -(RW'(sr[QB]) + RW'(rem[QB] != '0));
      end else begin
        quot <= RW'(sr[QB]);
      end
    end
  end

endmodule

>>> design/ray_triangle_intersect.sv
// Ray / triangle intersection top level: APB register port and ray pipeline.
// Rays pass capture, products, determinants, quotients, hit test, hit point, output.
// One ray per cycle unless the output stalls or the normal sequencer is busy; the three
// pipelines run in lockstep. After reset and after any vertex write, req_ready stays
// low while the normal sequencer runs. Reset is synchronous and clears all valid bits.
`timescale 1ns / 1ps

module ray_triangle_intersect (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rti_pkg::ADDR_W-1:0]  paddr,
  input  logic [rti_pkg::DATA_W-1:0]  pwdata,
  output logic [rti_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  rti_pkg::ray_t               req,
  output logic                        rsp_valid,
  input  logic                        rsp_ready,
  output rti_pkg::result_t            rsp
);

  localparam int CB = rti_pkg::COORD_BITS;
  localparam int EW = rti_pkg::EDGE_W;
  localparam int PW = rti_pkg::PROD_W;
  localparam int DW = rti_pkg::DIFF_W;
  localparam int TW = rti_pkg::TRIP_W;
  localparam int XW = rti_pkg::DET_W;
  localparam int MW = rti_pkg::MAG_W;
  localparam int RW = rti_pkg::RES_W;
  localparam int NW = rti_pkg::NRM_W;
  localparam int FB = rti_pkg::FRAC_BITS;
  localparam int DB = rti_pkg::DIST_BITS;
  localparam int DL = rti_pkg::DIV_LAT;
  localparam int QW = CB + RW;
  localparam int SW = QW - FB + 1;

  localparam int DR = 0;
  localparam int DM = 1;
  localparam int DP = 2;
  localparam int DQ = 3;
  localparam int DS = 4;
  localparam int DX = 5;

  localparam logic signed [RW-1:0] ONE_Q = RW'(1 << FB);
  localparam logic signed [RW-1:0] DMAX  = RW'((64'd1 << (DB - 1)) - 64'd1);
  localparam logic signed [RW-1:0] DMIN  = -DMAX - RW'(1);
  localparam logic signed [SW-1:0] CMAX  = SW'((1 << (CB - 1)) - 1);
  localparam logic signed [SW-1:0] CMIN  = -CMAX - SW'(1);
  localparam logic signed [DB-1:0] MISS_DIST = DB'(-(1 << FB));
  localparam logic signed [QW-1:0] HALF_Q = QW'(1 << (FB - 1));

  typedef struct packed {
    logic                   cmd;
    logic [2:0][CB-1:0]     o;
    logic [2:0][CB-1:0]     d;
    logic [DB-2:0]          maxt;
    logic                   dot_neg;
    logic                   a_nz;
  } side_t;

  // configuration
  logic [rti_pkg::VERT_W-1:0] vertex_a, vertex_b, vertex_c;
  logic [rti_pkg::EPS_W-1:0]  epsilon;
  logic [1:0]                 reg_idx;
  logic                       cfg_wr, vtx_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[rti_pkg::ADDR_W-1:3];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign vtx_wr  = cfg_wr && (reg_idx != rti_pkg::REG_EPSILON);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_a <= '0;
      vertex_b <= '0;
      vertex_c <= '0;
      epsilon  <= rti_pkg::EPS_W'(66);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        rti_pkg::REG_VERTEX_A: vertex_a <= pwdata[rti_pkg::VERT_W-1:0];
        rti_pkg::REG_VERTEX_B: vertex_b <= pwdata[rti_pkg::VERT_W-1:0];
        rti_pkg::REG_VERTEX_C: vertex_c <= pwdata[rti_pkg::VERT_W-1:0];
        rti_pkg::REG_EPSILON:  epsilon  <= pwdata[rti_pkg::EPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rti_pkg::REG_VERTEX_A: prdata = rti_pkg::DATA_W'(vertex_a);
      rti_pkg::REG_VERTEX_B: prdata = rti_pkg::DATA_W'(vertex_b);
      rti_pkg::REG_VERTEX_C: prdata = rti_pkg::DATA_W'(vertex_c);
      rti_pkg::REG_EPSILON:  prdata = rti_pkg::DATA_W'(epsilon);
      default:               prdata = '0;
    endcase
  end

  rti_pkg::geom_t geom;
  logic           setup_busy;

  rti_setup u_setup (
    .clk      (clk),
    .rst      (rst),
    .vertex_a (vertex_a),
    .vertex_b (vertex_b),
    .vertex_c (vertex_c),
    .start    (vtx_wr),
    .geom     (geom),
    .busy     (setup_busy)
  );

  // handshake
  logic en, acc;
  assign en        = !rsp_valid || rsp_ready;
  assign req_ready = en && !setup_busy;
  assign acc       = req_valid && req_ready;

  // stage 1: capture
  logic signed [CB-1:0] in_o [3], in_d [3], va [3];
  logic signed [EW-1:0] s1_ve [3];
  side_t                s1_sd;

  always_comb begin
    in_o[0] = req.ray_origin_x;
    in_o[1] = req.ray_origin_y;
    in_o[2] = req.ray_origin_z;
    in_d[0] = req.ray_dir_x;
    in_d[1] = req.ray_dir_y;
    in_d[2] = req.ray_dir_z;
    for (int i = 0; i < 3; i++) begin
      va[i] = $signed(vertex_a[i*CB +: CB]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_ve[i]   <= EW'(va[i]) - EW'(in_o[i]);
        s1_sd.o[i] <= in_o[i];
        s1_sd.d[i] <= in_d[i];
      end
      s1_sd.cmd     <= req.command;
      s1_sd.maxt    <= req.max_t;
      s1_sd.dot_neg <= 1'b0;
      s1_sd.a_nz    <= 1'b0;
    end
  end

  // stage 2: pair products
  logic signed [EW-1:0] ab [3], ac [3], de1 [3];
  logic signed [EW-1:0] ma [6], mb [6], mc [6], md [6];
  logic signed [PW-1:0] s2_pa [6], s2_pb [6];
  logic signed [2*NW-1:0] s2_dot [3];
  logic signed [EW-1:0] s2_ve [3];
  side_t                s2_sd;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ab[i]  = $signed(geom.ab[i]);
      ac[i]  = $signed(geom.ac[i]);
      de1[i] = EW'($signed(s1_sd.d[i]));
    end
    ma[DR] = ac[1];    mb[DR] = de1[2];   mc[DR] = ac[2];    md[DR] = de1[1];
    ma[DM] = ab[1];    mb[DM] = de1[2];   mc[DM] = ab[2];    md[DM] = de1[1];
    ma[DP] = s1_ve[1]; mb[DP] = de1[2];   mc[DP] = s1_ve[2]; md[DP] = de1[1];
    ma[DQ] = s1_ve[1]; mb[DQ] = ac[2];    mc[DQ] = s1_ve[2]; md[DQ] = ac[1];
    ma[DS] = ab[1];    mb[DS] = s1_ve[2]; mc[DS] = ab[2];    md[DS] = s1_ve[1];
    ma[DX] = ac[1];    mb[DX] = s1_ve[2]; mc[DX] = ac[2];    md[DX] = s1_ve[1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        s2_pa[k] <= ma[k] * mb[k];
        s2_pb[k] <= mc[k] * md[k];
      end
      for (int i = 0; i < 3; i++) begin
        s2_dot[i] <= $signed(s1_sd.d[i]) * $signed(geom.normal[i]);
        s2_ve[i]  <= s1_ve[i];
      end
      s2_sd <= s1_sd;
    end
  end

  // stage 3: 2x2 determinants
  logic signed [DW-1:0]   s3_df [6];
  logic signed [EW-1:0]   s3_ve [3];
  logic signed [2*NW+1:0] dot_sum;
  side_t                  s3_sd_next;
  side_t                  s3_sd;

  assign dot_sum = (2*NW+2)'(s2_dot[0]) + (2*NW+2)'(s2_dot[1]) + (2*NW+2)'(s2_dot[2]);

  always_comb begin
    s3_sd_next         = s2_sd;
    s3_sd_next.dot_neg = dot_sum < 0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 6; k++) begin
        s3_df[k] <= DW'(s2_pa[k]) - DW'(s2_pb[k]);
      end
      for (int i = 0; i < 3; i++) begin
        s3_ve[i] <= s2_ve[i];
      end
      s3_sd <= s3_sd_next;
    end
  end

  // stage 4: triple products
  logic signed [EW-1:0] te [4][3];
  logic signed [DW-1:0] tf [4][3];
  logic signed [DW-1:0] ld;
  logic signed [EW-1:0] de3 [3];
  logic signed [TW-1:0] s4_t [4][3];
  side_t                s4_sd;

  always_comb begin
    ld = $signed(geom.left_det);
    for (int i = 0; i < 3; i++) begin
      de3[i] = EW'($signed(s3_sd.d[i]));
    end
    te[0][0] = ab[0];    tf[0][0] = s3_df[DR];
    te[0][1] = ac[0];    tf[0][1] = s3_df[DM];
    te[0][2] = de3[0];   tf[0][2] = ld;
    te[1][0] = s3_ve[0]; tf[1][0] = s3_df[DR];
    te[1][1] = ac[0];    tf[1][1] = s3_df[DP];
    te[1][2] = de3[0];   tf[1][2] = s3_df[DQ];
    te[2][0] = ab[0];    tf[2][0] = s3_df[DP];
    te[2][1] = s3_ve[0]; tf[2][1] = s3_df[DM];
    te[2][2] = de3[0];   tf[2][2] = s3_df[DS];
    te[3][0] = ab[0];    tf[3][0] = s3_df[DX];
    te[3][1] = ac[0];    tf[3][1] = s3_df[DS];
    te[3][2] = s3_ve[0]; tf[3][2] = ld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 3; k++) begin
          s4_t[j][k] <= te[j][k] * tf[j][k];
        end
      end
      s4_sd <= s3_sd;
    end
  end

  // stage 5: 3x3 determinants (A, beta, gamma, t)
  logic signed [XW-1:0] s5_det [4];
  side_t                s5_sd;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        s5_det[j] <= XW'(s4_t[j][0]) - XW'(s4_t[j][1]) + XW'(s4_t[j][2]);
      end
      s5_sd <= s4_sd;
    end
  end

  // stage 6: sign normalization
  logic signed [XW-1:0] flip [4];
  logic [MW-1:0]        s6_mag [4];
  logic                 s6_neg [4];
  side_t                s6_sd_next;
  side_t                s6_sd;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      flip[j] = (s5_det[0] < 0) ? -s5_det[j] : s5_det[j];
    end
    s6_sd_next      = s5_sd;
    s6_sd_next.a_nz = s5_det[0] != '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        s6_neg[j] <= flip[j] < 0;
        s6_mag[j] <= (flip[j] < 0) ? MW'(-flip[j]) : MW'(flip[j]);
      end
      s6_sd <= s6_sd_next;
    end
  end

  // quotients
  logic signed [RW-1:0] q_beta, q_gamma, q_t;

  rti_div_pipe u_div_beta (
    .clk (clk), .en (en), .num (s6_mag[1]), .neg (s6_neg[1]), .den (s6_mag[0]),
    .quot (q_beta)
  );

  rti_div_pipe u_div_gamma (
    .clk (clk), .en (en), .num (s6_mag[2]), .neg (s6_neg[2]), .den (s6_mag[0]),
    .quot (q_gamma)
  );

  rti_div_pipe u_div_t (
    .clk (clk), .en (en), .num (s6_mag[3]), .neg (s6_neg[3]), .den (s6_mag[0]),
    .quot (q_t)
  );

  side_t dl [DL];

  always_ff @(posedge clk) begin
    if (en) begin
      dl[0] <= s6_sd;
      for (int k = 1; k < DL; k++) begin
        dl[k] <= dl[k-1];
      end
    end
  end

  // hit test
  logic signed [RW-1:0] neg_eps;
  logic signed [RW:0]   bg;
  logic                 hit_now;
  logic                 h_hit;
  logic signed [RW-1:0] h_t;
  side_t                h_sd;

  always_comb begin
    neg_eps = -$signed(RW'(epsilon));
    bg      = (RW+1)'(q_beta) + (RW+1)'(q_gamma);
    hit_now = dl[DL-1].a_nz && (q_beta >= neg_eps) && (q_beta <= ONE_Q) &&
              (q_gamma >= neg_eps) && (bg <= (RW+1)'(ONE_Q)) &&
              (q_t >= -neg_eps) &&
              ((dl[DL-1].cmd == rti_pkg::CMD_CLOSEST) ||
               (q_t <= $signed(RW'(dl[DL-1].maxt))));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_hit <= hit_now;
      h_t   <= q_t;
      h_sd  <= dl[DL-1];
    end
  end

  // hit point products
  logic signed [QW-1:0] p_prod [3];
  logic                 p_hit;
  logic signed [RW-1:0] p_t;
  side_t                p_sd;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_prod[i] <= $signed(h_sd.d[i]) * h_t;
      end
      p_hit <= h_hit;
      p_t   <= h_t;
      p_sd  <= h_sd;
    end
  end

  // output assembly
  logic signed [QW-1:0] rnd [3];
  logic signed [SW-1:0] pt_full [3];
  logic signed [CB-1:0] pt [3];
  logic signed [NW-1:0] nv [3];
  logic signed [DB-1:0] dist_sat;
  rti_pkg::result_t     rsp_next;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i]     = p_prod[i] + HALF_Q;
      pt_full[i] = SW'($signed(rnd[i][QW-1:FB])) + SW'($signed(p_sd.o[i]));
      if (pt_full[i] > CMAX) begin
        pt[i] = CB'(CMAX);
      end else if (pt_full[i] < CMIN) begin
        pt[i] = CB'(CMIN);
      end else begin
        pt[i] = CB'(pt_full[i]);
      end
      nv[i] = p_sd.dot_neg ? $signed(geom.normal[i]) : -$signed(geom.normal[i]);
    end
    if (p_t > DMAX) begin
      dist_sat = DB'(DMAX);
    end else if (p_t < DMIN) begin
      dist_sat = DB'(DMIN);
    end else begin
      dist_sat = DB'(p_t);
    end
    rsp_next = '0;
    rsp_next.hit = p_hit;
    if (!p_hit) begin
      rsp_next.distance = MISS_DIST;
    end else begin
      rsp_next.distance = dist_sat;
      if (p_sd.cmd == rti_pkg::CMD_CLOSEST) begin
        rsp_next.point_x  = pt[0];
        rsp_next.point_y  = pt[1];
        rsp_next.point_z  = pt[2];
        rsp_next.normal_x = nv[0];
        rsp_next.normal_y = nv[1];
        rsp_next.normal_z = nv[2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rsp <= rsp_next;
    end
  end

  // valid bits
  logic v1, v2, v3, v4, v5, v6, vh, vp;
  logic vd [DL];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      for (int k = 0; k < DL; k++) begin
        vd[k] <= 1'b0;
      end
      vh        <= 1'b0;
      vp        <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (en) begin
      v1    <= acc;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      v5    <= v4;
      v6    <= v5;
      vd[0] <= v6;
      for (int k = 1; k < DL; k++) begin
        vd[k] <= vd[k-1];
      end
      vh        <= vd[DL-1];
      vp        <= vh;
      rsp_valid <= vp;
    end
  end

endmodule
